@@ rtl/sliced_transport_color_step_defines.svh @@
// Assertion macros shared by the checker of the color transfer block
`ifndef SLICED_TRANSPORT_COLOR_STEP_DEFINES_SVH
`define SLICED_TRANSPORT_COLOR_STEP_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define STCS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define STCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/stcs_pkg.sv @@
// Shared types and constants of the sliced transport color step block
`timescale 1ns / 1ps
`default_nettype none
package stcs_pkg;
    localparam int FRAC_W = 14;
    localparam int COMP_W = 26;
    localparam int DIR_W  = 16;
    localparam int COL_W  = 8;
    localparam int KEY_W  = 29;
    localparam int CNT_W  = 13;

    localparam logic [1:0] OP_LOAD_SRC = 2'd0;
    localparam logic [1:0] OP_LOAD_MDL = 2'd1;
    localparam logic [1:0] OP_RUN      = 2'd2;
    localparam logic [1:0] OP_READ     = 2'd3;

    localparam logic [1:0] REG_DIR_X = 2'd0;
    localparam logic [1:0] REG_DIR_Y = 2'd1;
    localparam logic [1:0] REG_DIR_Z = 2'd2;
    localparam logic [1:0] REG_COUNT = 2'd3;

    typedef logic signed [COMP_W-1:0] t_comp;

    typedef struct packed {
        t_comp r;
        t_comp g;
        t_comp b;
    } t_src_pix;

    typedef struct packed {
        logic [COL_W-1:0] r;
        logic [COL_W-1:0] g;
        logic [COL_W-1:0] b;
    } t_mdl_pix;

    typedef struct packed {
        logic start;
        logic step;
        logic ld_we;
        logic bank;
    } t_sort_ctl;

    typedef struct packed {
        logic src;
        logic mdl;
    } t_store_we;
endpackage
`default_nettype wire

@@ rtl/stcs_store.sv @@
// Source and model pixel memories, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module stcs_store
    import stcs_pkg::*;
#(
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic      i_clk,
    input  wire t_store_we i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_src_pix  i_src_wdata,
    input  wire t_mdl_pix  i_mdl_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output t_src_pix       o_src,
    output t_mdl_pix       o_mdl
);
    t_src_pix r_src [DEPTH];
    t_mdl_pix r_mdl [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we.src) begin
            r_src[i_waddr] <= i_src_wdata;
        end
        o_src <= r_src[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.mdl) begin
            r_mdl[i_waddr] <= i_mdl_wdata;
        end
        o_mdl <= r_mdl[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/stcs_sort.sv @@
// Ping-pong rank memory with a merge unit that emits one entry per cycle while stepping
`timescale 1ns / 1ps
`default_nettype none
module stcs_sort
    import stcs_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int SW = 14,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic           i_clk,
    input  wire t_sort_ctl      i_ctl,
    input  wire logic [SW-1:0]  i_lo,
    input  wire logic [SW-1:0]  i_mid,
    input  wire logic [SW-1:0]  i_hi,
    input  wire logic [AW-1:0]  i_k,
    input  wire logic [AW-1:0]  i_raddr,
    input  wire logic [AW-1:0]  i_ld_addr,
    input  wire logic signed [KEY_W-1:0] i_ld_key,
    output logic signed [KEY_W-1:0] o_key,
    output logic [AW-1:0]       o_idx
);
    localparam int EW = KEY_W + AW;

    logic [EW-1:0] r_mem0 [DEPTH];
    logic [EW-1:0] r_mem1 [DEPTH];
    logic [EW-1:0] r_a;
    logic [EW-1:0] r_b;
    logic [SW-1:0] r_i;
    logic [SW-1:0] r_j;
    logic [SW-1:0] n_i;
    logic [SW-1:0] n_j;

    logic signed [KEY_W-1:0] a_key;
    logic signed [KEY_W-1:0] b_key;
    logic [AW-1:0] a_idx;
    logic [AW-1:0] b_idx;
    logic          b_first;
    logic          take_j;
    logic [AW-1:0] addr0;
    logic [AW-1:0] addr1;
    logic          we;
    logic          wbank;
    logic [AW-1:0] waddr;
    logic [EW-1:0] wdata;

    assign a_key = r_a[EW-1:AW];
    assign b_key = r_b[EW-1:AW];
    assign a_idx = r_a[AW-1:0];
    assign b_idx = r_b[AW-1:0];

    // order by key, then by pixel index
    assign b_first = (b_key < a_key) || ((b_key == a_key) && (b_idx < a_idx));
    assign take_j  = (r_j < i_hi) && ((r_i >= i_mid) || b_first);

    always_comb begin
        n_i = r_i;
        n_j = r_j;
        if (i_ctl.start) begin
            n_i = i_lo;
            n_j = i_mid;
        end else if (i_ctl.step) begin
            if (take_j) begin
                n_j = r_j + SW'(1);
            end else begin
                n_i = r_i + SW'(1);
            end
        end
    end

    assign addr0 = (i_ctl.start || i_ctl.step) ? n_i[AW-1:0] : i_raddr;
    assign addr1 = n_j[AW-1:0];

    assign we    = i_ctl.ld_we || i_ctl.step;
    assign wbank = i_ctl.ld_we ? 1'b0 : ~i_ctl.bank;
    assign waddr = i_ctl.ld_we ? i_ld_addr : i_k;
    assign wdata = i_ctl.ld_we ? {i_ld_key, i_ld_addr} : (take_j ? r_b : r_a);

    always_ff @(posedge i_clk) begin
        if (we && !wbank) begin
            r_mem0[waddr] <= wdata;
        end
        if (we && wbank) begin
            r_mem1[waddr] <= wdata;
        end
        if (i_ctl.bank) begin
            r_a <= r_mem1[addr0];
            r_b <= r_mem1[addr1];
        end else begin
            r_a <= r_mem0[addr0];
            r_b <= r_mem0[addr1];
        end
        r_i <= n_i;
        r_j <= n_j;
    end

    assign o_key = a_key;
    assign o_idx = a_idx;
endmodule
`default_nettype wire

@@ rtl/sliced_transport_color_step.sv @@
// Top level: sequencer and arithmetic of one sliced transport color step
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------------
//  in      | in        | i_in_valid / o_in_stall    | opcode, pixel_index, red/green/blue
//  out     | out       | o_out_valid / i_out_stall  | red/green/blue_out, status
//  cfg     | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// Loads and rejected items reply from idle; readouts read the source in ST_READ.
// A run loads keys, makes P = ceil(log2 n) merge passes over n pixels, then moves them;
// in merging, each rank memory writes one entry per cycle but pauses in ST_BLK.
// Reset is synchronous, active low; the stores are undefined until loaded.
// A result held on a stalled output does not block the next item; a second one does.
`timescale 1ns / 1ps
`default_nettype none
module sliced_transport_color_step
    import stcs_pkg::*;
#(
    parameter int PIXEL_DEPTH = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [11:0] i_pixel_index,
    input  wire logic [7:0]  i_red_in,
    input  wire logic [7:0]  i_green_in,
    input  wire logic [7:0]  i_blue_in,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_red_out,
    output logic [7:0]       o_green_out,
    output logic [7:0]       o_blue_out,
    output logic             o_status,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    localparam int AW = $clog2(PIXEL_DEPTH);
    localparam int PW = AW + 1;
    localparam int SW = AW + 2;
    localparam int CW = (PW > CNT_W) ? PW : CNT_W;
    localparam int SP_W = COMP_W + DIR_W;
    localparam int MP_W = COL_W + 1 + DIR_W;
    localparam int DIFF_W = KEY_W + 1;
    localparam int Q_W = DIFF_W + DIR_W;
    localparam t_comp SRC_MAX = {1'b0, {(COMP_W-1){1'b1}}};
    localparam t_comp SRC_MIN = {1'b1, {(COMP_W-1){1'b0}}};
    localparam t_comp READ_TOP = COMP_W'(255 * (1 << FRAC_W));

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_KEY  = 3'd2;
    localparam logic [2:0] ST_BLK  = 3'd3;
    localparam logic [2:0] ST_MRG  = 3'd4;
    localparam logic [2:0] ST_MOVE = 3'd5;

    function automatic logic [COL_W-1:0] read_comp(input t_comp raw);
        logic [COL_W-1:0] v;
        if (raw < 0) begin
            v = '0;
        end else if (raw >= READ_TOP) begin
            v = 8'd255;
        end else begin
            v = raw[FRAC_W+COL_W-1:FRAC_W];
        end
        return v;
    endfunction

    function automatic t_comp sat_comp(input logic signed [COMP_W+6:0] x);
        t_comp v;
        if (x > (COMP_W+7)'(SRC_MAX)) begin
            v = SRC_MAX;
        end else if (x < (COMP_W+7)'(SRC_MIN)) begin
            v = SRC_MIN;
        end else begin
            v = x[COMP_W-1:0];
        end
        return v;
    endfunction

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic signed [DIR_W-1:0] r_dir_x, r_dir_y, r_dir_z;
    logic [CNT_W-1:0] r_count;

    logic [PW-1:0] r_cnt;
    logic [PW-1:0] n_cnt;
    logic          r_kv1, r_kv2;
    logic [AW-1:0] r_ki1, r_ki2;
    logic signed [SP_W-1:0] r_sp0, r_sp1, r_sp2;
    logic signed [MP_W-1:0] r_mp0, r_mp1, r_mp2;

    logic [SW-1:0] r_w, r_lo;
    logic [SW-1:0] n_w, n_lo;
    logic [AW-1:0] r_k;
    logic [AW-1:0] n_k;
    logic          r_bank;
    logic          n_bank;

    logic          r_mv1, r_mv2, r_mv3;
    logic signed [DIFF_W-1:0] r_diff;
    logic [AW-1:0] r_pi2, r_pi3;
    logic signed [Q_W-1:0] r_q0, r_q1, r_q2;
    t_src_pix      r_c;

    logic          r_pv;
    logic          n_pv;
    logic [COL_W-1:0] r_pr, r_pg, r_pb;
    logic [COL_W-1:0] n_pr, n_pg, n_pb;
    logic          r_pst;
    logic          n_pst;
    logic          r_ov;

    logic [CW-1:0] pc_ext;
    logic [PW-1:0] use_n;
    logic [SW-1:0] n_sw;
    logic          in_acc;
    logic          idx_bad;
    logic          key_issue;
    logic          mv_issue;
    logic [SW-1:0] lo_w, lo_2w, mid, hi, nxt_lo, w2;

    t_sort_ctl     sctl;
    t_store_we     swe;
    logic [AW-1:0] s_waddr;
    logic [AW-1:0] s_raddr;
    t_src_pix      s_wdata;
    t_mdl_pix      m_wdata;
    t_src_pix      s_rdata;
    t_mdl_pix      m_rdata;

    logic signed [SP_W+1:0]  s_sum;
    logic signed [MP_W+1:0]  m_sum;
    logic signed [KEY_W-1:0] s_key_ld;
    logic signed [KEY_W-1:0] m_key_ld;
    logic signed [KEY_W-1:0] s_key;
    logic signed [KEY_W-1:0] m_key;
    logic [AW-1:0] s_idx;
    logic [AW-1:0] m_idx_unused;
    t_src_pix      mv_new;

    assign pc_ext = CW'(r_count);
    assign use_n  = (pc_ext > CW'(PIXEL_DEPTH)) ? PW'(PIXEL_DEPTH) : PW'(pc_ext);
    assign n_sw   = SW'(use_n);
    assign idx_bad = CW'(i_pixel_index) >= CW'(use_n);

    assign o_in_stall  = !((r_state == ST_IDLE) && !r_pv);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign key_issue = (r_state == ST_KEY) && (r_cnt < use_n);
    assign mv_issue  = (r_state == ST_MOVE) && (r_cnt < use_n);

    assign lo_w   = r_lo + r_w;
    assign lo_2w  = r_lo + (r_w << 1);
    assign mid    = (lo_w < n_sw) ? lo_w : n_sw;
    assign hi     = (lo_2w < n_sw) ? lo_2w : n_sw;
    assign nxt_lo = lo_2w;
    assign w2     = r_w << 1;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_x <= '0;
            r_dir_y <= '0;
            r_dir_z <= DIR_W'(1 << FRAC_W);
            r_count <= CNT_W'(4096);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DIR_X: r_dir_x <= i_cfg_data;
                REG_DIR_Y: r_dir_y <= i_cfg_data;
                REG_DIR_Z: r_dir_z <= i_cfg_data;
                REG_COUNT: r_count <= i_cfg_data[CNT_W-1:0];
                default:   r_count <= r_count;
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_w     = r_w;
        n_lo    = r_lo;
        n_k     = r_k;
        n_bank  = r_bank;
        n_pv    = r_pv;
        n_pr    = r_pr;
        n_pg    = r_pg;
        n_pb    = r_pb;
        n_pst   = r_pst;
        if (r_pv && (!r_ov || !i_out_stall)) begin
            n_pv = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_opcode == OP_RUN) begin
                        n_state = ST_KEY;
                        n_cnt   = '0;
                        n_bank  = 1'b0;
                    end else if (i_opcode == OP_READ && !idx_bad) begin
                        n_state = ST_READ;
                    end else begin
                        n_pv  = 1'b1;
                        n_pr  = '0;
                        n_pg  = '0;
                        n_pb  = '0;
                        n_pst = idx_bad;
                    end
                end
            end
            ST_READ: begin
                n_pv    = 1'b1;
                n_pr    = read_comp(s_rdata.r);
                n_pg    = read_comp(s_rdata.g);
                n_pb    = read_comp(s_rdata.b);
                n_pst   = 1'b0;
                n_state = ST_IDLE;
            end
            ST_KEY: begin
                if (key_issue) begin
                    n_cnt = r_cnt + PW'(1);
                end else if (!r_kv1 && !r_kv2) begin
                    n_w  = SW'(1);
                    n_lo = '0;
                    if (SW'(1) >= n_sw) begin
                        n_state = ST_MOVE;
                        n_cnt   = '0;
                    end else begin
                        n_state = ST_BLK;
                    end
                end
            end
            ST_BLK: begin
                n_k     = r_lo[AW-1:0];
                n_state = ST_MRG;
            end
            ST_MRG: begin
                n_k = r_k + AW'(1);
                if (SW'(r_k) + SW'(1) == hi) begin
                    if (nxt_lo >= n_sw) begin
                        // pass done: swap banks, double the run length
                        n_bank = ~r_bank;
                        n_w    = w2;
                        n_lo   = '0;
                        if (w2 >= n_sw) begin
                            n_state = ST_MOVE;
                            n_cnt   = '0;
                        end else begin
                            n_state = ST_BLK;
                        end
                    end else begin
                        n_lo    = nxt_lo;
                        n_state = ST_BLK;
                    end
                end
            end
            ST_MOVE: begin
                if (mv_issue) begin
                    n_cnt = r_cnt + PW'(1);
                end else if (!r_mv1 && !r_mv2 && !r_mv3) begin
                    n_pv    = 1'b1;
                    n_pr    = '0;
                    n_pg    = '0;
                    n_pb    = '0;
                    n_pst   = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
            r_kv1   <= 1'b0;
            r_kv2   <= 1'b0;
            r_mv1   <= 1'b0;
            r_mv2   <= 1'b0;
            r_mv3   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= n_pv;
            if (r_pv && (!r_ov || !i_out_stall)) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            r_kv1 <= key_issue;
            r_kv2 <= r_kv1;
            r_mv1 <= mv_issue;
            r_mv2 <= r_mv1;
            r_mv3 <= r_mv2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_w    <= n_w;
        r_lo   <= n_lo;
        r_k    <= n_k;
        r_bank <= n_bank;
        r_pr   <= n_pr;
        r_pg   <= n_pg;
        r_pb   <= n_pb;
        r_pst  <= n_pst;
        if (r_pv && (!r_ov || !i_out_stall)) begin
            o_red_out   <= r_pr;
            o_green_out <= r_pg;
            o_blue_out  <= r_pb;
            o_status    <= r_pst;
        end
    end

    assign o_out_valid = r_ov;

    // key pipeline: read pixel, multiply, sum and store key
    always_ff @(posedge i_clk) begin
        r_ki1 <= r_cnt[AW-1:0];
        r_ki2 <= r_ki1;
        r_sp0 <= s_rdata.r * r_dir_x;
        r_sp1 <= s_rdata.g * r_dir_y;
        r_sp2 <= s_rdata.b * r_dir_z;
        r_mp0 <= $signed({1'b0, m_rdata.r}) * r_dir_x;
        r_mp1 <= $signed({1'b0, m_rdata.g}) * r_dir_y;
        r_mp2 <= $signed({1'b0, m_rdata.b}) * r_dir_z;
    end

    assign s_sum    = (SP_W+2)'(r_sp0) + (SP_W+2)'(r_sp1) + (SP_W+2)'(r_sp2);
    assign m_sum    = (MP_W+2)'(r_mp0) + (MP_W+2)'(r_mp1) + (MP_W+2)'(r_mp2);
    assign s_key_ld = KEY_W'(s_sum >>> FRAC_W);
    assign m_key_ld = KEY_W'(m_sum);

    // move pipeline: ranks, pixel read, multiply, saturate and write back
    always_ff @(posedge i_clk) begin
        r_diff <= DIFF_W'(m_key) - DIFF_W'(s_key);
        r_pi2  <= s_idx;
        r_pi3  <= r_pi2;
        r_q0   <= r_diff * r_dir_x;
        r_q1   <= r_diff * r_dir_y;
        r_q2   <= r_diff * r_dir_z;
        r_c    <= s_rdata;
    end

    assign mv_new.r = sat_comp((COMP_W+7)'(r_c.r) + (COMP_W+7)'(r_q0 >>> FRAC_W));
    assign mv_new.g = sat_comp((COMP_W+7)'(r_c.g) + (COMP_W+7)'(r_q1 >>> FRAC_W));
    assign mv_new.b = sat_comp((COMP_W+7)'(r_c.b) + (COMP_W+7)'(r_q2 >>> FRAC_W));

    // store port steering
    always_comb begin
        swe.src = 1'b0;
        swe.mdl = 1'b0;
        s_waddr = AW'(i_pixel_index);
        s_wdata.r = t_comp'({4'b0, i_red_in, {FRAC_W{1'b0}}});
        s_wdata.g = t_comp'({4'b0, i_green_in, {FRAC_W{1'b0}}});
        s_wdata.b = t_comp'({4'b0, i_blue_in, {FRAC_W{1'b0}}});
        m_wdata.r = i_red_in;
        m_wdata.g = i_green_in;
        m_wdata.b = i_blue_in;
        if (r_mv3) begin
            swe.src = 1'b1;
            s_waddr = r_pi3;
            s_wdata = mv_new;
        end else if (in_acc && !idx_bad) begin
            swe.src = (i_opcode == OP_LOAD_SRC);
            swe.mdl = (i_opcode == OP_LOAD_MDL);
        end
        case (r_state)
            ST_KEY:  s_raddr = r_cnt[AW-1:0];
            ST_MOVE: s_raddr = s_idx;
            default: s_raddr = AW'(i_pixel_index);
        endcase
    end

    always_comb begin
        sctl.start = (r_state == ST_BLK);
        sctl.step  = (r_state == ST_MRG);
        sctl.ld_we = r_kv2;
        sctl.bank  = r_bank;
    end

    stcs_store #(
        .DEPTH(PIXEL_DEPTH)
    ) u_store (
        .i_clk      (i_clk),
        .i_we       (swe),
        .i_waddr    (s_waddr),
        .i_src_wdata(s_wdata),
        .i_mdl_wdata(m_wdata),
        .i_raddr    (s_raddr),
        .o_src      (s_rdata),
        .o_mdl      (m_rdata)
    );

    stcs_sort #(
        .DEPTH(PIXEL_DEPTH),
        .SW   (SW)
    ) u_sort_src (
        .i_clk    (i_clk),
        .i_ctl    (sctl),
        .i_lo     (r_lo),
        .i_mid    (mid),
        .i_hi     (hi),
        .i_k      (r_k),
        .i_raddr  (r_cnt[AW-1:0]),
        .i_ld_addr(r_ki2),
        .i_ld_key (s_key_ld),
        .o_key    (s_key),
        .o_idx    (s_idx)
    );

    stcs_sort #(
        .DEPTH(PIXEL_DEPTH),
        .SW   (SW)
    ) u_sort_mdl (
        .i_clk    (i_clk),
        .i_ctl    (sctl),
        .i_lo     (r_lo),
        .i_mid    (mid),
        .i_hi     (hi),
        .i_k      (r_k),
        .i_raddr  (r_cnt[AW-1:0]),
        .i_ld_addr(r_ki2),
        .i_ld_key (m_key_ld),
        .o_key    (m_key),
        .o_idx    (m_idx_unused)
    );
endmodule
`default_nettype wire

@@ rtl/stcs_check.sv @@
// Port-level checker for the color transfer block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "sliced_transport_color_step_defines.svh"
module stcs_check (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_red_out,
    input wire logic [7:0] o_green_out,
    input wire logic [7:0] o_blue_out,
    input wire logic       o_status
);
    `STCS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_red_out) && $stable(o_status), "stalled item changed")
    `STCS_ASSERT_NOW(a_bad_zero, o_out_valid && o_status,
        o_red_out == 8'd0 && o_green_out == 8'd0 && o_blue_out == 8'd0, "rejected item has color")
    `STCS_ASSERT_NEXT(a_one_at_a_time, i_in_valid && !o_in_stall, o_in_stall,
        "item taken while previous one in flight")
endmodule

bind sliced_transport_color_step stcs_check u_check (.*);
`default_nettype wire

@@ tb/tb_sliced_transport_color_step.sv @@
// Testbench for the sliced transport color step block: predictor, scoreboard and stimulus
`timescale 1ns / 1ps
module tb_sliced_transport_color_step;
    import stcs_pkg::*;

    localparam int DEPTH       = 4096;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int ITEM_TARGET = 1600;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       st;
    } color_result_t;

    class color_step_board;
        longint        src [DEPTH][3];
        bit            src_wr [DEPTH];
        longint        mdl [DEPTH][3];
        bit            mdl_wr [DEPTH];
        longint        dir [3];
        int            count;
        int            n_err;
        color_result_t pending_q [$];

        function new();
            dir[0] = 0;
            dir[1] = 0;
            dir[2] = 16384;
            count  = 4096;
            n_err  = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] d);
            case (idx)
                REG_DIR_X: dir[0] = longint'($signed(d));
                REG_DIR_Y: dir[1] = longint'($signed(d));
                REG_DIR_Z: dir[2] = longint'($signed(d));
                REG_COUNT: count = int'(d[12:0]);
            endcase
        endfunction

        function int in_use();
            return (count > DEPTH) ? DEPTH : count;
        endfunction

        function bit all_loaded(int n);
            if (n > 64) return 0;
            for (int i = 0; i < n; i++)
                if (!src_wr[i] || !mdl_wr[i]) return 0;
            return 1;
        endfunction

        function longint sat26(longint x);
            if (x > 33554431) return 33554431;
            if (x < -33554432) return -33554432;
            return x;
        endfunction

        // stable order: key ascending, then pixel index ascending
        function void rank_sort(ref longint key[], ref int pos[], input int n);
            longint k;
            int     p;
            int     j;
            for (int i = 1; i < n; i++) begin
                k = key[i];
                p = pos[i];
                j = i - 1;
                while (j >= 0 && (key[j] > k || (key[j] == k && pos[j] > p))) begin
                    key[j+1] = key[j];
                    pos[j+1] = pos[j];
                    j--;
                end
                key[j+1] = k;
                pos[j+1] = p;
            end
        endfunction

        function void transport_slice();
            int     n;
            longint skey[];
            longint mkey[];
            int     spos[];
            int     mpos[];
            longint diff;
            int     p;
            n = in_use();
            skey = new[n];
            mkey = new[n];
            spos = new[n];
            mpos = new[n];
            for (int i = 0; i < n; i++) begin
                skey[i] = (src[i][0] * dir[0] + src[i][1] * dir[1] + src[i][2] * dir[2]) >>> 14;
                mkey[i] = mdl[i][0] * dir[0] + mdl[i][1] * dir[1] + mdl[i][2] * dir[2];
                spos[i] = i;
                mpos[i] = i;
            end
            rank_sort(skey, spos, n);
            rank_sort(mkey, mpos, n);
            for (int i = 0; i < n; i++) begin
                p = spos[i];
                diff = mkey[i] - skey[i];
                for (int c = 0; c < 3; c++)
                    src[p][c] = sat26(src[p][c] + ((diff * dir[c]) >>> 14));
            end
        endfunction

        function logic [7:0] readout(longint raw);
            if (raw < 0) return 8'd0;
            if (raw >= 255 * 16384) return 8'd255;
            return 8'(raw >>> 14);
        endfunction

        function void note_item(logic [1:0] op, logic [11:0] idx,
                                logic [7:0] r, logic [7:0] g, logic [7:0] b);
            color_result_t res;
            res = '0;
            if (op == OP_RUN) begin
                transport_slice();
            end else if (int'(idx) >= in_use()) begin
                res.st = 1'b1;
            end else if (op == OP_LOAD_SRC) begin
                src[idx][0] = longint'(r) * 16384;
                src[idx][1] = longint'(g) * 16384;
                src[idx][2] = longint'(b) * 16384;
                src_wr[idx] = 1;
            end else if (op == OP_LOAD_MDL) begin
                mdl[idx][0] = r;
                mdl[idx][1] = g;
                mdl[idx][2] = b;
                mdl_wr[idx] = 1;
            end else begin
                res.r = readout(src[idx][0]);
                res.g = readout(src[idx][1]);
                res.b = readout(src[idx][2]);
            end
            pending_q.push_back(res);
        endfunction

        function void check_result(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic st);
            color_result_t exp_res;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result r=%0d g=%0d b=%0d status=%0d",
                         $time, r, g, b, st);
                n_err++;
                return;
            end
            exp_res = pending_q.pop_front();
            if (r !== exp_res.r) begin
                $display("%0t: red expected %0d actual %0d", $time, exp_res.r, r);
                n_err++;
            end
            if (g !== exp_res.g) begin
                $display("%0t: green expected %0d actual %0d", $time, exp_res.g, g);
                n_err++;
            end
            if (b !== exp_res.b) begin
                $display("%0t: blue expected %0d actual %0d", $time, exp_res.b, b);
                n_err++;
            end
            if (st !== exp_res.st) begin
                $display("%0t: status expected %0d actual %0d", $time, exp_res.st, st);
                n_err++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_opcode;
    logic [11:0] i_pixel_index;
    logic [7:0]  i_red_in;
    logic [7:0]  i_green_in;
    logic [7:0]  i_blue_in;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_red_out;
    logic [7:0]  o_green_out;
    logic [7:0]  o_blue_out;
    logic        o_status;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    sliced_transport_color_step u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_pixel_index (i_pixel_index),
        .i_red_in      (i_red_in),
        .i_green_in    (i_green_in),
        .i_blue_in     (i_blue_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_red_out     (o_red_out),
        .o_green_out   (o_green_out),
        .o_blue_out    (o_blue_out),
        .o_status      (o_status),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    color_step_board board = new();

    int     n_items;
    int     n_runs;
    int     n_reads;
    int     n_phases;
    int     burst_left;
    longint cycles;
    int     stall_mode;
    int     stall_left;

    // start low so the first rising edge comes after the initial values settle
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: check accepted results, then pick the next stall value
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_result(o_red_out, o_green_out, o_blue_out, o_status);
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(32, 200);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 9) < 7);
            default: i_out_stall <= ((cycles % 32) < 20);
        endcase
    end

    task automatic send_item(logic [1:0] op, logic [11:0] idx,
                             logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        burst_left--;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_opcode      <= op;
        i_pixel_index <= idx;
        i_red_in      <= r;
        i_green_in    <= g;
        i_blue_in     <= b;
        do @(posedge i_clk); while (o_in_stall);
        board.note_item(op, idx, r, g, b);
        n_items++;
        if (op == OP_RUN) n_runs++;
        if (op == OP_READ) n_reads++;
    endtask

    // drop valid and let every pending result drain
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(idx, d);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_all(logic [15:0] dx, logic [15:0] dy, logic [15:0] dz,
                           logic [15:0] cnt);
        drain();
        write_reg(REG_DIR_X, dx);
        write_reg(REG_DIR_Y, dy);
        write_reg(REG_DIR_Z, dz);
        write_reg(REG_COUNT, cnt);
        n_phases++;
    endtask

    function automatic logic [15:0] pick_dir();
        case ($urandom_range(0, 9))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'd0;
            3: return 16'h8000;
            4: return 16'h7fff;
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    task automatic run_phase(int k);
        int         n;
        int         sel;
        logic [1:0] op;
        logic [11:0] idx;
        bit         found;
        n = board.in_use();
        // with at most 64 pixels in use, load every one so runs and readouts see defined data
        if (n <= 64) begin
            for (int i = 0; i < n; i++) begin
                if (!board.src_wr[i])
                    send_item(OP_LOAD_SRC, 12'(i), 8'($urandom), 8'($urandom),
                              8'($urandom));
                if (!board.mdl_wr[i])
                    send_item(OP_LOAD_MDL, 12'(i), 8'($urandom), 8'($urandom),
                              8'($urandom));
            end
        end
        for (int j = 0; j < k; j++) begin
            sel = $urandom_range(0, 99);
            idx = (n > 0) ? 12'($urandom_range(0, n - 1)) : 12'($urandom);
            if (sel < 20) begin
                op = OP_RUN;
            end else if (sel < 55) begin
                op = OP_READ;
            end else if (sel < 70) begin
                op = OP_LOAD_SRC;
            end else if (sel < 85) begin
                op = OP_LOAD_MDL;
            end else begin
                op = 2'($urandom);
                idx = 12'($urandom);
            end
            if (op == OP_RUN && !board.all_loaded(n))
                op = OP_LOAD_SRC;
            if (op == OP_READ && int'(idx) < n && !board.src_wr[idx]) begin
                found = 0;
                for (int t = 0; t < 16 && !found; t++) begin
                    idx = 12'($urandom_range(0, n - 1));
                    found = board.src_wr[idx];
                end
                if (!found) op = OP_LOAD_SRC;
            end
            send_item(op, idx, 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        cycles        <= 0;
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_opcode      <= OP_LOAD_SRC;
        i_pixel_index <= '0;
        i_red_in      <= '0;
        i_green_in    <= '0;
        i_blue_in     <= '0;
        i_out_stall   <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= REG_DIR_X;
        i_cfg_data    <= '0;
        n_items = 0;
        n_runs = 0;
        n_reads = 0;
        n_phases = 0;
        burst_left = 0;
        stall_mode = 0;
        stall_left = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes under reset settings
        send_item(OP_LOAD_SRC, 12'd0, 8'd0, 8'd0, 8'd0);
        send_item(OP_LOAD_SRC, 12'd4095, 8'd255, 8'd255, 8'd255);
        send_item(OP_LOAD_MDL, 12'd0, 8'd255, 8'd0, 8'd255);
        send_item(OP_LOAD_MDL, 12'd4095, 8'd0, 8'd255, 8'd0);
        send_item(OP_READ, 12'd0, 8'd0, 8'd0, 8'd0);
        send_item(OP_READ, 12'd4095, 8'd0, 8'd0, 8'd0);
        send_item(OP_LOAD_SRC, 12'd1, 8'd170, 8'd85, 8'd15);
        send_item(OP_LOAD_MDL, 12'd1, 8'd1, 8'd128, 8'd254);
        // two pixels, tie on the projection, then a normal run
        set_all(16'd0, 16'd0, 16'd0, 16'd2);
        send_item(OP_RUN, 12'd0, 8'd0, 8'd0, 8'd0);
        set_all(16'sd16384, -16'sd16384, 16'sd9459, 16'd2);
        send_item(OP_RUN, 12'd0, 8'd0, 8'd0, 8'd0);
        send_item(OP_READ, 12'd0, 8'd0, 8'd0, 8'd0);
        send_item(OP_READ, 12'd1, 8'd0, 8'd0, 8'd0);
        send_item(OP_READ, 12'd2, 8'd0, 8'd0, 8'd0);
        // no pixels in use: nothing moves, everything is out of range
        set_all(16'sd16384, 16'sd16384, 16'sd16384, 16'd0);
        send_item(OP_RUN, 12'd0, 8'd0, 8'd0, 8'd0);
        send_item(OP_LOAD_SRC, 12'd0, 8'd9, 8'd9, 8'd9);
        send_item(OP_READ, 12'd0, 8'd0, 8'd0, 8'd0);
        // single pixel pairs with the single model pixel
        set_all(16'h8000, 16'h7fff, 16'h8000, 16'd1);
        send_item(OP_RUN, 12'd0, 8'd0, 8'd0, 8'd0);
        send_item(OP_RUN, 12'd0, 8'd0, 8'd0, 8'd0);
        send_item(OP_READ, 12'd0, 8'd0, 8'd0, 8'd0);
        // count above the depth is limited to the depth
        set_all(16'd0, 16'd0, 16'sd16384, 16'h1fff);
        send_item(OP_READ, 12'd4095, 8'd0, 8'd0, 8'd0);
        send_item(OP_LOAD_MDL, 12'd4095, 8'd7, 8'd7, 8'd7);

        while (n_items < ITEM_TARGET) begin
            case ($urandom_range(0, 19))
                0: set_all(pick_dir(), pick_dir(), pick_dir(), 16'd0);
                1: set_all(pick_dir(), pick_dir(), pick_dir(), 16'd1);
                2: set_all(pick_dir(), pick_dir(), pick_dir(), 16'd2);
                3: set_all(pick_dir(), pick_dir(), pick_dir(), 16'h1fff);
                4: set_all(pick_dir(), pick_dir(), pick_dir(), 16'd4096);
                default: set_all(pick_dir(), pick_dir(), pick_dir(),
                                 16'($urandom_range(2, 48)));
            endcase
            run_phase($urandom_range(30, 90));
        end

        drain();
        repeat (50) @(posedge i_clk);
        $display("Sent %0d items over %0d register settings: %0d transport steps, %0d readouts",
                 n_items, n_phases, n_runs, n_reads);
        $display("Mismatches: %0d, results still outstanding: %0d",
                 board.n_err, board.pending_q.size());
        if (board.n_err == 0 && board.pending_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
